// File: sv/line_squared_distance_transform_core_macros.svh
// Assertion macros for the line squared distance transform core.
// Used by the top level; expects a clock named clk and a reset named rst.
`ifndef LINE_SQUARED_DISTANCE_TRANSFORM_CORE_MACROS_SVH
`define LINE_SQUARED_DISTANCE_TRANSFORM_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LSDT_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define LSDT_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// File: sv/lsdt_pkg.sv
// Shared constants and types of the line squared distance transform core.
// No dependencies; imported by lsdt_cross_unit, the core and the testbench.
package lsdt_pkg;

  localparam int MAX_LINE = 64;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int VAL_W    = 41;
  localparam int NUM_W    = 46;
  localparam int DEN_W    = 7;
  localparam int BND_W    = NUM_W + DEN_W;
  localparam int PROD_W   = NUM_W + DEN_W + 1;

  localparam logic [VAL_W-1:0] FAR_VALUE     = VAL_W'(64'd1 << 40);
  localparam logic [VAL_W:0]   FAR_THRESHOLD = (VAL_W + 1)'(64'd1 << 39);

  // Operands of the shared cross-product comparator.
  typedef struct packed {
    logic signed [NUM_W-1:0] a_num;
    logic [DEN_W-1:0]        a_den;
    logic signed [NUM_W-1:0] b_num;
    logic [DEN_W-1:0]        b_den;
  } cross_op_t;

endpackage

// File: sv/lsdt_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module lsdt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first in the source, read returns the old contents on a collision.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lsdt_cross_unit.sv
// Shared cross-product comparator: registers a_num*b_den and b_num*a_den,
// then flags a_num/a_den > b_num/b_den in the cycle after. Uses lsdt_pkg.
module lsdt_cross_unit (
  input  logic               clk,
  input  lsdt_pkg::cross_op_t op,
  output logic               gt
);
  import lsdt_pkg::*;

  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_b;

  // One product pair per cycle; denominators are positive.
  always_ff @(posedge clk) begin
    prod_a <= PROD_W'(op.a_num * $signed({1'b0, op.b_den}));
    prod_b <= PROD_W'(op.b_num * $signed({1'b0, op.a_den}));
  end

  assign gt = prod_a > prod_b;

endmodule

// File: sv/line_squared_distance_transform_core.sv
// One-dimensional squared distance transform of a line of up to 64 elements, by the lower
// envelope of parabolas. Elements are taken one a cycle; the element with tlast, or the 64th,
// closes the line, and the block then stops taking items until it has delivered one result per
// position, in order, with tlast on the last. After a set-up state the envelope build reads,
// lifts, compares and decides for each element and for each envelope pop, and the output scan
// reads, multiplies and tests per position and per boundary crossed, then waits on the receiver.
// All of this is set by one shared cross-product comparator and the single read port of each
// memory. Values above 2^40 load as 2^40; results saturate at 2^40.
module line_squared_distance_transform_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [40:0] sample_value, upper bits zero
  input  logic        s_tlast,   // end_of_line
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [40:0] distance_sq, [41] is_far, upper bits zero
  output logic        m_tlast    // last_out
);
  import lsdt_pkg::*;

  typedef enum logic [3:0] {
    ST_LOAD, ST_INIT, ST_LQ, ST_FQ, ST_RDT, ST_SITE, ST_LV, ST_CMP, ST_DEC,
    ST_ORD, ST_OMUL, ST_OTST, ST_OLV, ST_OOUT
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        load_count;
  logic [CNT_W-1:0]        n;
  logic [CNT_W-1:0]        q;
  logic [CNT_W-1:0]        p;
  logic [IDX_W-1:0]        top;
  logic [IDX_W-1:0]        k;
  logic [IDX_W-1:0]        site;
  logic [VAL_W:0]          fq;
  logic signed [NUM_W-1:0] num;
  logic [DEN_W-1:0]        den;
  logic [VAL_W-1:0]        distance;
  logic                    far;
  logic                    last;

  logic                    line_we;
  logic [IDX_W-1:0]        line_raddr;
  logic [VAL_W-1:0]        line_rdata;
  logic [VAL_W-1:0]        sample_sat;
  logic                    sites_we;
  logic [IDX_W-1:0]        sites_waddr;
  logic [IDX_W-1:0]        sites_wdata;
  logic [IDX_W-1:0]        sites_raddr;
  logic [IDX_W-1:0]        sites_rdata;
  logic                    bnd_we;
  logic [CNT_W-1:0]        bnd_raddr;
  logic [BND_W-1:0]        bnd_rdata;
  cross_op_t               op;
  logic                    gt;
  logic [VAL_W:0]          fv;
  logic [VAL_W+1:0]        d_sum;
  logic signed [IDX_W:0]   delta;
  logic signed [2*IDX_W+1:0] delta_sq;
  logic [CNT_W-1:0]        n_next;

  // Input saturation and handshakes.
  assign s_tready   = (state == ST_LOAD);
  assign sample_sat = (s_tdata[VAL_W-1:0] > FAR_VALUE) ? FAR_VALUE : s_tdata[VAL_W-1:0];
  assign line_we    = s_tvalid && s_tready;
  assign n_next     = load_count + CNT_W'(1);
  assign m_tvalid   = (state == ST_OOUT);
  assign m_tdata    = {6'd0, far, distance};
  assign m_tlast    = last;

  // Memory addressing follows the sequencer state.
  always_comb begin
    line_raddr = sites_rdata;
    if (state == ST_LQ) begin
      line_raddr = q[IDX_W-1:0];
    end
  end

  assign sites_raddr = (state == ST_ORD || state == ST_OMUL || state == ST_OTST) ? k : top;
  assign bnd_raddr   = (state == ST_ORD || state == ST_OMUL || state == ST_OTST) ?
                       ({1'b0, k} + CNT_W'(1)) : {1'b0, top};
  assign sites_we    = (state == ST_INIT) || (state == ST_DEC && (top == '0 || gt));
  assign sites_waddr = (state == ST_INIT) ? '0 : top + IDX_W'(1);
  assign sites_wdata = (state == ST_INIT) ? '0 : q[IDX_W-1:0];
  assign bnd_we      = (state == ST_DEC) && (top == '0 || gt);

  // Comparator operands: boundary test in the build, p against a boundary in the scan.
  always_comb begin
    op.b_num = $signed(bnd_rdata[BND_W-1:DEN_W]);
    op.b_den = bnd_rdata[DEN_W-1:0];
    if (state == ST_CMP) begin
      op.a_num = num;
      op.a_den = den;
    end else begin
      op.a_num = NUM_W'(p);
      op.a_den = DEN_W'(1);
    end
  end

  // Lifted value of the site now read, and the candidate result sum.
  assign fv       = {1'b0, line_rdata} + (VAL_W + 1)'(sites_rdata * sites_rdata);
  assign delta    = $signed({1'b0, p[IDX_W-1:0]}) - $signed({1'b0, site});
  assign delta_sq = delta * delta;
  assign d_sum    = {2'b0, line_rdata} + (VAL_W + 2)'($unsigned(delta_sq));

  lsdt_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LINE)) u_line (
    .clk(clk), .we(line_we), .waddr(load_count[IDX_W-1:0]), .wdata(sample_sat),
    .raddr(line_raddr), .rdata(line_rdata)
  );

  lsdt_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LINE)) u_sites (
    .clk(clk), .we(sites_we), .waddr(sites_waddr), .wdata(sites_wdata),
    .raddr(sites_raddr), .rdata(sites_rdata)
  );

  lsdt_ram #(.WIDTH(BND_W), .DEPTH(MAX_LINE + 1)) u_bnd (
    .clk(clk), .we(bnd_we), .waddr({1'b0, top} + CNT_W'(1)), .wdata({num, den}),
    .raddr(bnd_raddr), .rdata(bnd_rdata)
  );

  lsdt_cross_unit u_cross (.clk(clk), .op(op), .gt(gt));

  // Sequencer: load, envelope build, output scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      top        <= '0;
      n          <= '0;
      q          <= '0;
      p          <= '0;
      k          <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (line_we) begin
            load_count <= n_next;
            if (s_tlast || n_next == CNT_W'(MAX_LINE)) begin
              n     <= n_next;
              state <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          top <= '0;
          q   <= CNT_W'(1);
          p   <= '0;
          k   <= '0;
          state <= (n == CNT_W'(1)) ? ST_ORD : ST_LQ;
        end
        ST_LQ: state <= ST_FQ;
        ST_FQ: begin
          fq    <= {1'b0, line_rdata} + (VAL_W + 1)'(q[IDX_W-1:0] * q[IDX_W-1:0]);
          state <= ST_LV;
        end
        ST_RDT:  state <= ST_SITE;
        ST_SITE: state <= ST_LV;
        ST_LV: begin
          num   <= NUM_W'($signed({1'b0, fq}) - $signed({1'b0, fv}));
          den   <= {q[IDX_W-1:0] - sites_rdata, 1'b0};
          state <= ST_CMP;
        end
        ST_CMP: state <= ST_DEC;
        ST_DEC: begin
          if (top == '0 || gt) begin
            top <= top + IDX_W'(1);
            q   <= q + CNT_W'(1);
            state <= (q + CNT_W'(1) == n) ? ST_ORD : ST_LQ;
          end else begin
            top   <= top - IDX_W'(1);
            state <= ST_RDT;
          end
        end
        ST_ORD:  state <= ST_OMUL;
        ST_OMUL: state <= ST_OTST;
        ST_OTST: begin
          if (k < top && gt) begin
            k     <= k + IDX_W'(1);
            state <= ST_ORD;
          end else begin
            site  <= sites_rdata;
            state <= ST_OLV;
          end
        end
        ST_OLV: begin
          distance <= (d_sum > (VAL_W + 2)'(FAR_VALUE)) ? FAR_VALUE : d_sum[VAL_W-1:0];
          far      <= (d_sum >= (VAL_W + 2)'(FAR_THRESHOLD));
          last     <= (p + CNT_W'(1) == n);
          state    <= ST_OOUT;
        end
        ST_OOUT: begin
          if (m_tready) begin
            p <= p + CNT_W'(1);
            if (last) begin
              load_count <= '0;
              top        <= '0;
              state      <= ST_LOAD;
            end else begin
              state <= ST_ORD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // Checks on the sequencer.
`include "line_squared_distance_transform_core_macros.svh"

  `LSDT_ASSERT_NOW(a_no_overlap, s_tready, !m_tvalid, "input taken while a result waits")
  `LSDT_ASSERT_NOW(a_top_bound, state != ST_LOAD, {1'b0, top} < n, "envelope top beyond line")
  `LSDT_ASSERT_NEXT(a_line_done, m_tvalid && m_tready && m_tlast, s_tready && load_count == '0,
                    "block not ready for a new line after the last result")

endmodule

// File: tb/lsdt_checker.sv
// Checker for the line squared distance transform core: watches both streams,
// predicts the transform of each closed line and compares every result item.
// Depends on lsdt_pkg for widths and the far constants.
`timescale 1ns / 100ps

module lsdt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);
  import lsdt_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0] distance;
    logic             far;
    logic             last;
  } dist_item_t;

  dist_item_t        expected_dists[$];
  logic [VAL_W-1:0]  line_vals[MAX_LINE];
  int                line_len;

  assign pending = expected_dists.size();

  // Lower envelope of parabolas with exact fractional boundaries.
  task automatic transform_line(input int n);
    int          sites[MAX_LINE];
    longint      bnum[MAX_LINE+1];
    longint      bden[MAX_LINE+1];
    int          top, k, v, s;
    longint      num, den, dl;
    logic [63:0] d;
    dist_item_t  r;
    top = 0;
    sites[0] = 0;
    for (int q = 1; q < n; q++) begin
      forever begin
        v = sites[top];
        num = (longint'(line_vals[q]) + q * q) - (longint'(line_vals[v]) + v * v);
        den = 2 * (q - v);
        if (top == 0) break;
        if (num * bden[top] > bnum[top] * den) break;
        top--;
      end
      top++;
      sites[top] = q;
      bnum[top] = num;
      bden[top] = den;
    end
    k = 0;
    for (int p = 0; p < n; p++) begin
      while (k < top && bnum[k+1] < p * bden[k+1]) k++;
      s = sites[k];
      dl = p - s;
      d = dl * dl + line_vals[s];
      if (d > FAR_VALUE) d = FAR_VALUE;
      r.distance = d[VAL_W-1:0];
      r.far      = (d >= FAR_THRESHOLD);
      r.last     = (p + 1 == n);
      expected_dists.push_back(r);
    end
  endtask

  // Input side: store elements and close lines.
  always @(posedge clk) begin
    logic [VAL_W-1:0] v;
    if (rst) begin
      line_len = 0;
    end else if (s_tvalid && s_tready) begin
      v = s_tdata[VAL_W-1:0];
      if (v > FAR_VALUE) v = FAR_VALUE;
      line_vals[line_len] = v;
      line_len++;
      if (s_tlast || line_len == MAX_LINE) begin
        transform_line(line_len);
        line_len = 0;
      end
    end
  end

  // Output side: compare against the oldest expectation.
  always @(posedge clk) begin
    dist_item_t e;
    if (rst) begin
      fail_count = 0;
    end else if (m_tvalid && m_tready) begin
      if (expected_dists.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result item %h", m_tdata);
      end else begin
        e = expected_dists.pop_front();
        if (m_tdata[VAL_W-1:0] !== e.distance || m_tdata[VAL_W] !== e.far ||
            m_tlast !== e.last || m_tdata[47:VAL_W+1] !== '0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected dist %h far %b last %b, got dist %h far %b last %b",
                     e.distance, e.far, e.last, m_tdata[VAL_W-1:0], m_tdata[VAL_W], m_tlast);
        end
      end
    end
  end

endmodule

// File: tb/tb_top.sv
// Top of the testbench for the line squared distance transform core: clock,
// reset, line stimulus with random gaps and stalls, and the verdict.
// Depends on lsdt_pkg, the core and lsdt_checker.
`timescale 1ns / 100ps

module tb_top;
  import lsdt_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  int          fail_count;
  int          pending;
  int          hold_cycles = 0;

  always #6 clk = ~clk;

  line_squared_distance_transform_core DUT (.*);

  lsdt_checker u_checker (.*);

  // Send one element, waiting the given gap first; valid stays up after acceptance
  // so that the next item can follow at once.
  task automatic send_elem(input logic [VAL_W-1:0] v, input logic last, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, v};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return FAR_VALUE;
      1: return VAL_W'({$urandom, $urandom});
      2: return VAL_W'($urandom_range(0, 100));
      3: return FAR_VALUE - VAL_W'($urandom_range(0, 3));
      default: return VAL_W'($urandom_range(0, 5000));
    endcase
  endfunction

  task automatic send_line(input int n, input bit gaps);
    for (int i = 0; i < n; i++)
      send_elem(rand_value(), i == n - 1, gaps ? $urandom_range(0, 11) : 0);
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0) ? 1'b1 : ($urandom_range(0, 11) == 0);
        @(negedge clk);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL line_squared_distance_transform_core");
    $finish;
  end

  initial begin
    int cnt;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Directed: single elements, extremes, values above far, equal boundaries.
    send_elem(41'd0, 1'b1, 0);
    send_elem(FAR_VALUE, 1'b1, 0);
    send_elem(41'h1ff_ffff_ffff, 1'b1, 0);
    send_elem(FAR_VALUE, 1'b0, 0);
    send_elem(41'd0, 1'b0, 0);
    send_elem(FAR_VALUE, 1'b1, 0);
    send_elem(41'd4, 1'b0, 1);
    send_elem(41'd0, 1'b0, 1);
    send_elem(41'd4, 1'b0, 1);
    send_elem(41'd0, 1'b1, 1);
    send_elem(FAR_VALUE - 41'd1, 1'b0, 0);
    send_elem(41'h155_5555_5555, 1'b0, 0);
    send_elem(41'h0aa_aaaa_aaaa, 1'b1, 0);
    s_tvalid <= 1'b0;
    // Sender pauses until every result has come.
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    // Over-long line closes at the 64th element; receiver holds off meanwhile.
    hold_cycles = 1500;
    for (int i = 0; i < MAX_LINE; i++) send_elem(rand_value(), 1'b0, 0);
    send_elem(41'd7, 1'b1, 0);
    // Random lines, mostly short.
    cnt = 0;
    while (cnt < 32) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_LINE) : $urandom_range(1, 8);
      send_line(n, $urandom_range(0, 2) != 0);
      cnt += n;
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS line_squared_distance_transform_core");
    end else begin
      $display("FAIL line_squared_distance_transform_core");
    end
    $finish;
  end

endmodule
